// ===== design/mmcdbs_pkg.sv =====
// Package for the MMC data block serializer: widths, line constants, the
// tail state type and the CRC-16/XMODEM byte update. No dependencies.
`timescale 1ns / 1ps

package mmcdbs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned VBITS_W = 4;

    localparam logic [CRC_W-1:0]   CRC_POLY        = 16'h1021;
    localparam logic [VBITS_W-1:0] VALID_BITS_FULL = 4'd8;
    localparam logic [VBITS_W-1:0] VALID_BITS_TAIL = 4'd2;

    // Phases of the trailer that follows the last data byte of a block.
    typedef enum logic [1:0] {
        TAIL_IDLE,
        TAIL_CRC_HI,
        TAIL_CRC_LO,
        TAIL_END
    } t_tail_state;

    // Absorbs one byte, MSB first, into a CRC-16/XMODEM value.
    function automatic logic [CRC_W-1:0] crc16_absorb(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/mmc_data_block_serializer_unit.sv =====
// Top level of the MMC data block serializer: framing of single-line data
// blocks with start bit, CRC-16/XMODEM and end bit. Depends on mmcdbs_pkg.
`timescale 1ns / 1ps

// The unit takes the payload bytes of one single-line data block, one item
// per cycle, and returns the line stream in byte-sized items. A leading start
// bit 0 shifts the whole stream by one bit, so each data item yields the
// previous byte's last bit followed by the top seven bits of the current
// byte. The CRC-16/XMODEM of the payload is updated in the same cycle that a
// byte is accepted. The byte marked with block_end gives its data item and
// then three more: the CRC high byte, the CRC low byte (both shifted the same
// way), and a two-bit tail holding the last CRC bit and the end bit 1, with
// frame_done set. After the tail, CRC and carry are back at zero for the
// next block. An ordinary byte is accepted in every cycle that the output
// register is free or is being emptied; after a last byte the input is
// stalled until the three trailer items have been loaded, because they come
// from the same output register. Each data item is registered and appears
// in the cycle after its byte is accepted.
module mmc_data_block_serializer_unit
    import mmcdbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Payload byte channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_block_end,
    // Line byte channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_line_byte,
    output logic [VBITS_W-1:0] o_valid_bits,
    output logic               o_frame_done
);

    // Control state.
    t_tail_state        r_tail, n_tail;
    logic               r_out_valid, n_out_valid;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic               r_carry, n_carry;

    // Output payload register.
    logic [BYTE_W-1:0]  r_line, n_line;
    logic [VBITS_W-1:0] r_vbits, n_vbits;
    logic               r_done, n_done;

    logic               out_free;
    logic               in_accept;
    logic [CRC_W-1:0]   crc_next;

    // The output register can take a new item when it is empty or its
    // current item leaves in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_tail != TAIL_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign crc_next   = crc16_absorb(r_crc, i_data_byte);

    // Next state of the trailer sequencer.
    always_comb begin
        n_tail = r_tail;
        case (r_tail)
            TAIL_IDLE: begin
                if (in_accept && i_block_end) begin
                    n_tail = TAIL_CRC_HI;
                end
            end
            TAIL_CRC_HI: begin
                if (out_free) begin
                    n_tail = TAIL_CRC_LO;
                end
            end
            TAIL_CRC_LO: begin
                if (out_free) begin
                    n_tail = TAIL_END;
                end
            end
            TAIL_END: begin
                if (out_free) begin
                    n_tail = TAIL_IDLE;
                end
            end
            default: begin
                n_tail = TAIL_IDLE;
            end
        endcase
    end

    // Output register load, CRC and carry updates.
    always_comb begin
        n_out_valid = r_out_valid;
        n_line      = r_line;
        n_vbits     = r_vbits;
        n_done      = r_done;
        n_crc       = r_crc;
        n_carry     = r_carry;
        case (r_tail)
            TAIL_IDLE: begin
                if (in_accept) begin
                    n_out_valid = 1'b1;
                    n_line      = {r_carry, i_data_byte[BYTE_W-1:1]};
                    n_vbits     = VALID_BITS_FULL;
                    n_done      = 1'b0;
                    n_carry     = i_data_byte[0];
                    n_crc       = crc_next;
                end else if (out_free) begin
                    n_out_valid = 1'b0;
                end
            end
            TAIL_CRC_HI: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_line      = {r_carry, r_crc[CRC_W-1:BYTE_W+1]};
                    n_vbits     = VALID_BITS_FULL;
                    n_done      = 1'b0;
                end
            end
            TAIL_CRC_LO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_line      = r_crc[BYTE_W:1];
                    n_vbits     = VALID_BITS_FULL;
                    n_done      = 1'b0;
                end
            end
            TAIL_END: begin
                if (out_free) begin
                    // Last CRC bit, then the end bit; unused bits are zero.
                    n_out_valid = 1'b1;
                    n_line      = {r_crc[0], 1'b1, {(BYTE_W-2){1'b0}}};
                    n_vbits     = VALID_BITS_TAIL;
                    n_done      = 1'b1;
                    n_crc       = '0;
                    n_carry     = 1'b0;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail      <= TAIL_IDLE;
            r_out_valid <= 1'b0;
            r_crc       <= '0;
            r_carry     <= 1'b0;
        end else begin
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
            r_carry     <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line  <= n_line;
        r_vbits <= n_vbits;
        r_done  <= n_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_byte  = r_line;
    assign o_valid_bits = r_vbits;
    assign o_frame_done = r_done;

endmodule

// ===== design/mmcdbs_checker.sv =====
// Port-level checker for the MMC data block serializer and its bind to the
// top level. Depends on mmcdbs_pkg.
`timescale 1ns / 1ps

module mmcdbs_checker
    import mmcdbs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [BYTE_W-1:0]  i_data_byte,
    input logic               i_block_end,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [BYTE_W-1:0]  o_line_byte,
    input logic [VBITS_W-1:0] o_valid_bits,
    input logic               o_frame_done
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_byte)
            && $stable(o_valid_bits) && $stable(o_frame_done))
        else $error("stalled line item changed");

    // Only full bytes and the two-bit tail appear.
    a_bits_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_bits == VALID_BITS_FULL && !o_frame_done)
            || (o_valid_bits == VALID_BITS_TAIL && o_frame_done))
        else $error("illegal valid_bits or frame_done");

    // The tail carries the end bit and zero padding.
    a_tail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_line_byte[BYTE_W-2:0] == 7'h40)
        else $error("tail item malformed");

    // After a last byte the trailer holds the input off.
    a_trailer_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_block_end |=> o_in_stall && o_out_valid
            && !o_frame_done)
        else $error("input taken during block trailer");

endmodule

bind mmc_data_block_serializer_unit mmcdbs_checker u_mmcdbs_checker (.*);

// ===== bench/mmc_data_block_serializer_unit_tb.sv =====
// Testbench for mmc_data_block_serializer_unit: drives payload bytes and checks the
// framed line items against a built-in predictor. Depends on mmcdbs_pkg and the unit.
`timescale 1ns / 1ps

module mmc_data_block_serializer_unit_tb;
    import mmcdbs_pkg::*;

    // One row of stimulus. When typed is set, the expected line bytes are given in
    // lines, first item in lines[0]; the valid bit count and the done flag follow
    // from the item's position in the frame.
    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   last;
        logic                   typed;
        logic [3:0][BYTE_W-1:0] lines;
    } t_stim_row;

    // One item on the line side.
    typedef struct packed {
        logic [BYTE_W-1:0]  line;
        logic [VBITS_W-1:0] vbits;
        logic               done;
    } t_line_item;

    localparam int DIRECTED_ROWS = 14;
    localparam int RANDOM_ITEMS  = 466;
    localparam int HOLD_START    = 200;   // receiver cycle at which the long hold-off begins
    localparam int HOLD_CYCLES   = 64;
    localparam int STUCK_LIMIT   = 1000;  // cycles without any accepted item
    localparam int DRAIN_CYCLES  = 4;     // a last byte keeps the unit busy while its trailer goes out

    // Directed part: extremes of the payload byte, carries of both values, single-byte
    // blocks, tails with the last CRC bit at 0 and at 1, and ordinary multi-byte blocks.
    // Note that concatenations list the last item first.
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // A single zero byte right after reset: all-zero CRC, tail holds only the end bit.
        '{8'h00, 1'b1, 1'b1, {8'h40, 8'h00, 8'h00, 8'h00}},
        // Carry is back at the start bit, so 0xff loses its low bit.
        '{8'hff, 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, 8'h7f}},
        '{8'hff, 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, 8'hff}},
        '{8'h00, 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, 8'h80}},
        '{8'h80, 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, 8'h40}},
        '{8'h01, 1'b0, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00}},
        '{8'hfe, 1'b1, 1'b0, '0},
        // Single byte 0x01: CRC 0x1021, whose last bit 1 lands in the tail.
        '{8'h01, 1'b1, 1'b1, {8'hc0, 8'h10, 8'h88, 8'h00}},
        '{8'hff, 1'b1, 1'b0, '0},
        '{8'haa, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h7f, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h55, 1'b1, 1'b0, '0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic               i_block_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [BYTE_W-1:0]  o_line_byte;
    logic [VBITS_W-1:0] o_valid_bits;
    logic               o_frame_done;

    t_stim_row  stim_q [$];
    t_line_item pending_line_items [$];

    // Predictor state: running CRC of the block and the line bit waiting to go out.
    logic [CRC_W-1:0] crc_acc = '0;
    logic             line_carry = 1'b0;

    int send_idx = 0;
    int accepted_cnt = 0;
    int err_cnt = 0;
    int stuck_cycles = 0;

    mmc_data_block_serializer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_block_end  (i_block_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_byte  (o_line_byte),
        .o_valid_bits (o_valid_bits),
        .o_frame_done (o_frame_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // CRC-16/XMODEM, one bit at a time: the feedback is the CRC's top bit XOR the
    // incoming data bit, MSB of the byte first.
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic fb;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb  = crc[CRC_W-1] ^ data[i];
            crc = crc << 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Emits a byte on the line behind the waiting carry bit; its low bit becomes the
    // new carry.
    task automatic push_shifted(input logic [BYTE_W-1:0] data);
        pending_line_items.push_back('{{line_carry, data[BYTE_W-1:1]}, VALID_BITS_FULL, 1'b0});
        line_carry = data[0];
    endtask

    // Works out the line items caused by one payload byte: one for an ordinary byte,
    // and for the last byte of a block also both CRC bytes and the two-bit tail.
    task automatic predict_line_items(input logic [BYTE_W-1:0] data, input logic last);
        crc_acc = crc_update(crc_acc, data);
        push_shifted(data);
        if (last) begin
            push_shifted(crc_acc[15:8]);
            push_shifted(crc_acc[7:0]);
            // Tail: last CRC bit, end bit 1, six unused bits that must read zero.
            pending_line_items.push_back('{{line_carry, 1'b1, 6'b000000}, VALID_BITS_TAIL, 1'b1});
            crc_acc    = '0;
            line_carry = 1'b0;
        end
    endtask

    // Sender: bursts of random length separated by random gaps, some gaps of zero so
    // that long runs of back-to-back items happen too. A stalled item is held as is.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                send_idx = send_idx + 1;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (send_idx < stim_q.size()) begin
                    i_in_valid  <= 1'b1;
                    i_data_byte <= stim_q[send_idx].data;
                    i_block_end <= stim_q[send_idx].last;
                    if (burst_left > 1) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall rate switches periodically among none, light and heavy.
    // Once, it holds off for a long stretch so the output register fills and the unit
    // has to stall its input while the sender keeps offering items.
    int rcv_cycles = 0;
    int hold_left = 0;
    int stall_pct = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rcv_cycles = rcv_cycles + 1;
            if (rcv_cycles == HOLD_START) begin
                hold_left = HOLD_CYCLES;
            end
            if (rcv_cycles % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Monitor: predicts on every accepted payload byte, then checks every accepted
    // line item against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        int         first;
        t_line_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                first = pending_line_items.size();
                predict_line_items(i_data_byte, i_block_end);
                // Rows with typed expectations replace the predicted line bytes.
                if (stim_q[accepted_cnt].typed) begin
                    for (int k = first; k < pending_line_items.size(); k++) begin
                        pending_line_items[k].line = stim_q[accepted_cnt].lines[k - first];
                    end
                end
                accepted_cnt = accepted_cnt + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_line_items.size() == 0) begin
                    $error("unexpected line item: line_byte %h", o_line_byte);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = pending_line_items.pop_front();
                    if (o_line_byte !== want.line) begin
                        $error("line_byte: expected %h, got %h", want.line, o_line_byte);
                        err_cnt = err_cnt + 1;
                    end
                    if (o_valid_bits !== want.vbits) begin
                        $error("valid_bits: expected %0d, got %0d", want.vbits, o_valid_bits);
                        err_cnt = err_cnt + 1;
                    end
                    if (o_frame_done !== want.done) begin
                        $error("frame_done: expected %0d, got %0d", want.done, o_frame_done);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
    end

    // Watchdog: a run where nothing moves on either side for too long has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles = stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row row;
        int        blk_len;

        foreach (DIRECTED[r]) begin
            stim_q.push_back(DIRECTED[r]);
        end

        // Random blocks: mostly a few dozen bytes, sometimes a single byte, with the
        // payload biased a little toward the all-zero and all-one bytes.
        while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
            blk_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            for (int k = 0; k < blk_len; k++) begin
                case ($urandom_range(0, 9))
                    0:       row.data = 8'h00;
                    1:       row.data = 8'hff;
                    default: row.data = BYTE_W'($urandom_range(0, 255));
                endcase
                row.last  = (k == blk_len - 1);
                row.typed = 1'b0;
                row.lines = '0;
                stim_q.push_back(row);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(accepted_cnt == stim_q.size() && pending_line_items.size() == 0)) begin
            @(posedge i_clk);
        end
        // Any item the unit sends after the last expected one shows up here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
